FILE: sv/flacc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the filtered luxel accumulator.
// No dependencies; every other file refers to it by scoped names.
package flacc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // 2^24 / 6 rounded up: exact floor divide by 6 for 19-bit operands
  localparam logic [21:0] DIV6_MUL = 22'd2796203;
  localparam logic [18:0] K_OFS    = 19'd196608;   // 6 * 32768
  localparam logic [18:0] K_SAT    = 19'd393215;

  typedef enum logic [2:0] {
    REG_RADIUS  = 3'd0,
    REG_SCALE   = 3'd1,
    REG_CUBIC_B = 3'd2,
    REG_CUBIC_C = 3'd3,
    REG_MIN_X   = 3'd4,
    REG_MIN_Y   = 3'd5,
    REG_MAX_X   = 3'd6,
    REG_MAX_Y   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [23:0] radius;
    logic        [15:0] scale;
    logic        [15:0] cubic_b;
    logic        [15:0] cubic_c;
    logic signed [23:0] min_x;
    logic signed [23:0] min_y;
    logic signed [23:0] max_x;
    logic signed [23:0] max_y;
  } cfg_t;

  typedef struct packed {
    logic [23:0] mag_x;
    logic [23:0] mag_y;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        hit;
    logic        in_face;
    logic        last;
  } item_t;

endpackage

FILE: sv/flacc_front.sv
`timescale 1ns / 1ps
// Front end: face overlap test, patch offsets and radius check per word.
// Depends on flacc_pkg.
module flacc_front (
  input  flacc_pkg::cfg_t     cfg_i,
  input  logic signed [23:0]  luxel_x_i,
  input  logic signed [23:0]  luxel_y_i,
  input  logic signed [23:0]  patch_x_i,
  input  logic signed [23:0]  patch_y_i,
  input  logic [15:0]         red_i,
  input  logic [15:0]         green_i,
  input  logic [15:0]         blue_i,
  input  logic                visible_i,
  input  logic                last_i,
  output flacc_pkg::item_t    item_o
);

  function automatic logic overlap(logic signed [23:0] lo, logic signed [23:0] hi,
                                   logic signed [23:0] p, logic [23:0] r);
    logic signed [27:0] lhs;
    logic signed [27:0] rhs;
    lhs = 28'(hi) - 28'(lo) + $signed({3'b000, r, 1'b0});
    rhs = (28'(p) <<< 1) - 28'(lo) - 28'(hi);
    if (rhs < 0) begin
      rhs = -rhs;
    end
    return lhs >= rhs;
  endfunction

  logic signed [24:0] dx, dy;
  logic        [24:0] ax, ay;
  logic               face;

  always_comb begin
    face = overlap(cfg_i.min_x, cfg_i.max_x, luxel_x_i, cfg_i.radius)
        && overlap(cfg_i.min_y, cfg_i.max_y, luxel_y_i, cfg_i.radius);
    dx = 25'(patch_x_i) - 25'(luxel_x_i);
    dy = 25'(patch_y_i) - 25'(luxel_y_i);
    ax = dx[24] ? 25'(-dx) : 25'(dx);
    ay = dy[24] ? 25'(-dy) : 25'(dy);
    item_o.mag_x   = ax[23:0];
    item_o.mag_y   = ay[23:0];
    item_o.red     = red_i;
    item_o.green   = green_i;
    item_o.blue    = blue_i;
    item_o.in_face = face;
    item_o.last    = last_i;
    item_o.hit     = face && visible_i && (ax <= {1'b0, cfg_i.radius})
                  && (ay <= {1'b0, cfg_i.radius});
  end

endmodule

FILE: sv/flacc_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified words between front end and back end.
// Depends on flacc_pkg.
module flacc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  flacc_pkg::item_t  item_i,
  output logic              full_o,
  output logic              valid_o,
  output flacc_pkg::item_t  item_o,
  input  logic              pop_i
);

  flacc_pkg::item_t              mem_q [flacc_pkg::QDEPTH];
  logic [flacc_pkg::QAW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [flacc_pkg::QAW:0]       cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (flacc_pkg::QAW+1)'(push_i) - (flacc_pkg::QAW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign full_o  = cnt_q == (flacc_pkg::QAW+1)'(flacc_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

endmodule

FILE: sv/flacc_back.sv
`timescale 1ns / 1ps
// Back end: sequencer around one shared multiplier that evaluates both cubic
// kernels, the weight and the weighted colours, and owns the sums. Depends on flacc_pkg.
module flacc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flacc_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  flacc_pkg::item_t  q_item_i,
  output logic              q_pop_o,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [151:0]      out_data_o,
  output logic              out_face_o
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_T    = 16'h0002,
    ST_TT   = 16'h0004,
    ST_TTT  = 16'h0008,
    ST_C3   = 16'h0010,
    ST_C2   = 16'h0020,
    ST_C1   = 16'h0040,
    ST_SUM  = 16'h0080,
    ST_DV   = 16'h0100,
    ST_K    = 16'h0200,
    ST_W    = 16'h0400,
    ST_WS   = 16'h0800,
    ST_AR   = 16'h1000,
    ST_AG   = 16'h2000,
    ST_AB   = 16'h4000,
    ST_DONE = 16'h8000
  } state_e;

  function automatic logic [39:0] sat40(logic [39:0] a, logic signed [33:0] d);
    logic signed [41:0] s;
    s = $signed({2'b00, a}) + 42'(d);
    if (s < 0) begin
      return '0;
    end else if (s[41:40] != 2'b00) begin
      return '1;
    end
    return s[39:0];
  endfunction

  function automatic logic [31:0] sat32(logic [31:0] a, logic signed [17:0] d);
    logic signed [33:0] s;
    s = $signed({2'b00, a}) + 34'(d);
    if (s < 0) begin
      return '0;
    end else if (s[33:32] != 2'b00) begin
      return '1;
    end
    return s[31:0];
  endfunction

  state_e                state_q, state_d;
  flacc_pkg::item_t      item_q;
  logic                  axis_q;
  logic [16:0]           t_q;
  logic                  big_q;
  logic [33:0]           tt_q;
  logic signed [47:0]    acc_q;
  logic signed [15:0]    kx_q, ky_q, k_d;
  logic signed [17:0]    w_q;
  logic signed [59:0]    p_q, p_d;
  logic signed [35:0]    mul_a;
  logic signed [23:0]    mul_b;
  logic [39:0]           red_q, green_q, blue_q;
  logic [31:0]           wt_q;
  logic                  ovalid_q;
  logic [151:0]          odata_q;
  logic                  oface_q;

  logic signed [23:0]    bs, cs, c3, c2, c1, c0;
  logic signed [47:0]    c0_ext;
  logic signed [31:0]    v;
  logic [18:0]           u;
  logic                  out_free;

  // Kernel coefficients of the inner (t < 1) and outer segment.
  always_comb begin
    bs = $signed({8'b0, cfg_i.cubic_b});
    cs = $signed({8'b0, cfg_i.cubic_c});
    if (!t_q[16]) begin
      c3 = 24'(24'sd196608 - 24'sd9 * bs - 24'sd6 * cs);
      c2 = 24'(-24'sd294912 + 24'sd12 * bs + 24'sd6 * cs);
      c1 = '0;
      c0 = 24'(24'sd98304 - 24'sd2 * bs);
    end else begin
      c3 = 24'(-bs - 24'sd6 * cs);
      c2 = 24'(24'sd6 * bs + 24'sd30 * cs);
      c1 = 24'(-24'sd12 * bs - 24'sd48 * cs);
      c0 = 24'(24'sd8 * bs + 24'sd24 * cs);
    end
    c0_ext = 48'(c0) <<< 16;
  end

  // Clamp the Q.14 sum times 6, then offset it so the divide by 6 is unsigned.
  always_comb begin
    v = acc_q[47:16];
    if (v >= 32'sd196608) begin
      u = flacc_pkg::K_SAT;
    end else if (v < -32'sd196608) begin
      u = '0;
    end else begin
      u = 19'(v + 32'sd196608);
    end
    k_d = big_q ? 16'sd0 : $signed({~p_q[39], p_q[38:24]});
  end

  // Operand select of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_T: begin
        mul_a = $signed({12'b0, (axis_q ? item_q.mag_y : item_q.mag_x)});
        mul_b = $signed({8'b0, cfg_i.scale});
      end
      ST_TT: begin
        mul_a = $signed({19'b0, p_q[16:0]});
        mul_b = $signed({7'b0, p_q[16:0]});
      end
      ST_TTT: begin
        mul_a = $signed({2'b0, p_q[33:0]});
        mul_b = $signed({7'b0, t_q});
      end
      ST_C3: begin
        mul_a = $signed({17'b0, p_q[50:32]});
        mul_b = c3;
      end
      ST_C2: begin
        mul_a = $signed({18'b0, tt_q[33:16]});
        mul_b = c2;
      end
      ST_C1: begin
        mul_a = $signed({19'b0, t_q});
        mul_b = c1;
      end
      ST_DV: begin
        mul_a = $signed({17'b0, u});
        mul_b = $signed({2'b0, flacc_pkg::DIV6_MUL});
      end
      ST_W: begin
        mul_a = 36'(kx_q);
        mul_b = 24'(ky_q);
      end
      ST_WS: begin
        mul_a = 36'($signed(p_q[31:14]));
        mul_b = $signed({8'b0, item_q.red});
      end
      ST_AR: begin
        mul_a = 36'(w_q);
        mul_b = $signed({8'b0, item_q.green});
      end
      ST_AG: begin
        mul_a = 36'(w_q);
        mul_b = $signed({8'b0, item_q.blue});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    p_d = 60'(mul_a) * 60'(mul_b);
  end

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_item_i.hit ? ST_T : ST_DONE;
        end
      end
      ST_T:    state_d = ST_TT;
      ST_TT:   state_d = ST_TTT;
      ST_TTT:  state_d = ST_C3;
      ST_C3:   state_d = ST_C2;
      ST_C2:   state_d = ST_C1;
      ST_C1:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_DV;
      ST_DV:   state_d = ST_K;
      ST_K:    state_d = axis_q ? ST_W : ST_T;
      ST_W:    state_d = ST_WS;
      ST_WS:   state_d = ST_AR;
      ST_AR:   state_d = ST_AG;
      ST_AG:   state_d = ST_AB;
      ST_AB:   state_d = ST_DONE;
      ST_DONE: begin
        if (!item_q.last || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      wt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_AR: red_q   <= sat40(red_q, $signed(p_q[33:0]));
        ST_AG: green_q <= sat40(green_q, $signed(p_q[33:0]));
        ST_AB: begin
          blue_q <= sat40(blue_q, $signed(p_q[33:0]));
          wt_q   <= sat32(wt_q, w_q);
        end
        ST_DONE: begin
          if (item_q.last && out_free) begin
            ovalid_q <= 1'b1;
            red_q    <= '0;
            green_q  <= '0;
            blue_q   <= '0;
            wt_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    unique case (state_q)
      ST_IDLE: begin
        item_q <= q_item_i;
        axis_q <= 1'b0;
      end
      ST_TT: begin
        t_q   <= p_q[16:0];
        big_q <= |p_q[39:17];
      end
      ST_TTT: tt_q  <= p_q[33:0];
      ST_C3:  acc_q <= c0_ext;
      ST_C2:  acc_q <= acc_q + p_q[47:0];
      ST_C1:  acc_q <= acc_q + p_q[47:0];
      ST_SUM: acc_q <= acc_q + p_q[47:0];
      ST_K: begin
        if (axis_q) begin
          ky_q <= k_d;
        end else begin
          kx_q   <= k_d;
          axis_q <= 1'b1;
        end
      end
      ST_WS: w_q <= $signed(p_q[31:14]);
      ST_DONE: begin
        if (item_q.last && out_free) begin
          odata_q <= {wt_q, blue_q, green_q, red_q};
          oface_q <= item_q.in_face;
        end
      end
      default: ;
    endcase
  end

  assign busy_o      = state_q != ST_IDLE;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_face_o  = oface_q;

endmodule

FILE: sv/filtered_luxel_accumulator_core.sv
`timescale 1ns / 1ps
// Top level of the filtered luxel accumulator: configuration registers,
// front end, word queue and kernel back end. Depends on flacc_pkg and the flacc_* modules.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata patch word, tuser visible, tlast end of run
//  m_axis    out  m_axis_tvalid/tready       tdata sums, tuser in_face
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i register, cfg_data_i value
//
// A patch that contributes passes through the kernel, weight and colour states in turn, all
// served by the single shared multiplier that evaluates both kernels, the weight and three colours.
// A patch that adds nothing goes from idle straight to the done state. A four-word queue decouples input.
// Reset loads the default kernel (B-spline), unit scale and radius, zero sums.
// A finished result waits in the output register; the back end stalls only
// when the next run end finds that register still full.
module filtered_luxel_accumulator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // luxel_x, luxel_y, patch_x, patch_y, color_red, color_green, color_blue
  input  logic [143:0]  s_axis_tdata,
  // visible
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // sum_red, sum_green, sum_blue, weight_total
  output logic [151:0]  m_axis_tdata,
  // in_face
  output logic          m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i
);

  flacc_pkg::cfg_t   cfg_q;
  flacc_pkg::item_t  f_item, q_item;
  logic              q_full, q_valid, q_pop, push, busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{radius: 24'd256, scale: 16'd256, cubic_b: 16'd16384, cubic_c: 16'd0,
                 min_x: 24'sd0, min_y: 24'sd0, max_x: 24'sd0, max_y: 24'sd0};
    end else if (cfg_valid_i) begin
      unique case (flacc_pkg::reg_idx_e'(cfg_index_i))
        flacc_pkg::REG_RADIUS:  cfg_q.radius  <= cfg_data_i;
        flacc_pkg::REG_SCALE:   cfg_q.scale   <= cfg_data_i[15:0];
        flacc_pkg::REG_CUBIC_B: cfg_q.cubic_b <= cfg_data_i[15:0];
        flacc_pkg::REG_CUBIC_C: cfg_q.cubic_c <= cfg_data_i[15:0];
        flacc_pkg::REG_MIN_X:   cfg_q.min_x   <= $signed(cfg_data_i);
        flacc_pkg::REG_MIN_Y:   cfg_q.min_y   <= $signed(cfg_data_i);
        flacc_pkg::REG_MAX_X:   cfg_q.max_x   <= $signed(cfg_data_i);
        flacc_pkg::REG_MAX_Y:   cfg_q.max_y   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  flacc_front u_front (
    .cfg_i     (cfg_q),
    .luxel_x_i ($signed(s_axis_tdata[23:0])),
    .luxel_y_i ($signed(s_axis_tdata[47:24])),
    .patch_x_i ($signed(s_axis_tdata[71:48])),
    .patch_y_i ($signed(s_axis_tdata[95:72])),
    .red_i     (s_axis_tdata[111:96]),
    .green_i   (s_axis_tdata[127:112]),
    .blue_i    (s_axis_tdata[143:128]),
    .visible_i (s_axis_tuser),
    .last_i    (s_axis_tlast),
    .item_o    (f_item)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  flacc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  flacc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_face_o  (m_axis_tuser)
  );

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_result_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy)) else $error("result without back end work");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid) else $error("input stalled with empty queue");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for filtered_luxel_accumulator_core: predicts the filtered
// luxel sums per run and checks every result word. Depends on flacc_pkg and the core.
module tb_top;

  typedef struct {
    logic signed [23:0] lx, ly, px, py;
    logic [15:0] red, green, blue;
    logic vis, last;
  } patch_t;

  typedef struct {
    logic [39:0] r, g, b;
    logic [31:0] w;
    logic        in_face;
  } luxel_sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tuser = 1'b0, s_axis_tlast = 1'b0;
  logic [143:0] s_axis_tdata = '0;
  logic s_axis_tready;
  logic m_axis_tvalid, m_axis_tuser;
  logic m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  flacc_pkg::reg_idx_e cfg_index_i = flacc_pkg::REG_RADIUS;
  logic [23:0] cfg_data_i = '0;

  filtered_luxel_accumulator_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  longint radius, scale, cb, cc, min_x, min_y, max_x, max_y;
  longint acc_r, acc_g, acc_b, acc_w;

  patch_t pending_patches[$];
  luxel_sum_t expected_sums[$];
  int errors = 0, results_seen = 0, runs_sent = 0, items_sent = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint cubic_weight(longint mag);
    longint t, t2, t3, acc, k;
    t = mag * scale;
    if (t >= 131072) return 0;
    t2 = (t * t) >>> 16;
    t3 = longint'(((t * t) * t) >>> 32);
    if (t < 65536)
      acc = (12 * 16384 - 9 * cb - 6 * cc) * t3 + (-18 * 16384 + 12 * cb + 6 * cc) * t2
          + (6 * 16384 - 2 * cb) * 65536;
    else
      acc = (-cb - 6 * cc) * t3 + (6 * cb + 30 * cc) * t2 + (-12 * cb - 48 * cc) * t
          + (8 * cb + 24 * cc) * 65536;
    k = fdiv(acc, 6 * 65536);
    if (k > 32767) k = 32767;
    if (k < -32768) k = -32768;
    return k;
  endfunction

  function automatic longint sat(longint a, longint d, longint mx);
    longint s;
    s = a + d;
    if (s < 0) return 0;
    if (s > mx) return mx;
    return s;
  endfunction

  function automatic bit overlaps(longint lo, longint hi, longint p);
    longint v;
    v = 2 * p - lo - hi;
    if (v < 0) v = -v;
    return (hi - lo) + 2 * radius >= v;
  endfunction

  task automatic accumulate_patch(patch_t p);
    longint dx, dy, w;
    luxel_sum_t s;
    bit inf;
    inf = overlaps(min_x, max_x, p.lx) && overlaps(min_y, max_y, p.ly);
    dx = longint'(p.px) - longint'(p.lx);
    dy = longint'(p.py) - longint'(p.ly);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (inf && p.vis && dx <= radius && dy <= radius) begin
      w = fdiv(cubic_weight(dx) * cubic_weight(dy), 16384);
      acc_r = sat(acc_r, w * longint'(p.red), 64'hFF_FFFF_FFFF);
      acc_g = sat(acc_g, w * longint'(p.green), 64'hFF_FFFF_FFFF);
      acc_b = sat(acc_b, w * longint'(p.blue), 64'hFF_FFFF_FFFF);
      acc_w = sat(acc_w, w, 64'hFFFF_FFFF);
    end
    if (p.last) begin
      s.r = 40'(acc_r); s.g = 40'(acc_g); s.b = 40'(acc_b); s.w = 32'(acc_w);
      s.in_face = inf;
      expected_sums = {expected_sums, s};
      acc_r = 0; acc_g = 0; acc_b = 0; acc_w = 0;
    end
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // driver: bursts of random length, random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    patch_t p;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_patch(pending_patches.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_patches.size() != 0) begin
        p = pending_patches[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.blue, p.green, p.red, p.py, p.px, p.ly, p.lx};
        s_axis_tuser <= p.vis;
        s_axis_tlast <= p.last;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    luxel_sum_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_sums.size() == 0) report("unexpected result", m_axis_tdata[39:0], 0);
      else begin
        e = expected_sums.pop_front();
        if (m_axis_tdata[39:0] != e.r) report("sum_red", m_axis_tdata[39:0], e.r);
        if (m_axis_tdata[79:40] != e.g) report("sum_green", m_axis_tdata[79:40], e.g);
        if (m_axis_tdata[119:80] != e.b) report("sum_blue", m_axis_tdata[119:80], e.b);
        if (m_axis_tdata[151:120] != e.w) report("weight_total", m_axis_tdata[151:120], e.w);
        if (m_axis_tuser != e.in_face) report("in_face", m_axis_tuser, e.in_face);
      end
    end
  end

  task automatic write_reg(flacc_pkg::reg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      flacc_pkg::REG_RADIUS:  radius = val;
      flacc_pkg::REG_SCALE:   scale = val[15:0];
      flacc_pkg::REG_CUBIC_B: cb = val[15:0];
      flacc_pkg::REG_CUBIC_C: cc = val[15:0];
      flacc_pkg::REG_MIN_X:   min_x = longint'($signed(val));
      flacc_pkg::REG_MIN_Y:   min_y = longint'($signed(val));
      flacc_pkg::REG_MAX_X:   max_x = longint'($signed(val));
      flacc_pkg::REG_MAX_Y:   max_y = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_patches.size() != 0 || expected_sums.size() != 0) @(posedge clk_i);
    // a trailing patch without result may still be in the back end
    repeat (200) @(posedge clk_i);
  endtask

  task automatic add_patch(logic signed [23:0] lx, ly, px, py, logic [15:0] r, g, b,
                           logic vis, last);
    patch_t p;
    p.lx = lx; p.ly = ly; p.px = px; p.py = py;
    p.red = r; p.green = g; p.blue = b; p.vis = vis; p.last = last;
    pending_patches = {pending_patches, p};
    items_sent++;
    if (last) runs_sent++;
  endtask

  // a run around a random luxel with patches mostly near it
  task automatic random_run(int len, int spread);
    logic signed [23:0] lx, ly;
    lx = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 8192)) - 4096);
    ly = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 8192)) - 4096);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_patch(lx, ly, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), i == len - 1);
      else
        add_patch(lx, ly, lx + 24'($signed($urandom_range(0, 2 * spread)) - spread),
                  ly + 24'($signed($urandom_range(0, 2 * spread)) - spread),
                  16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 7) != 0, i == len - 1);
    end
  endtask

  initial begin
    radius = 256; scale = 256; cb = 16384; cc = 0;
    min_x = 0; min_y = 0; max_x = 0; max_y = 0;
    acc_r = 0; acc_g = 0; acc_b = 0; acc_w = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset defaults, extremes, exact centre, edge of radius
    add_patch(0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
    add_patch(0, 0, 256, -256, 16'h0100, 0, 16'h8000, 1, 0);
    add_patch(0, 0, 257, 0, 16'hFFFF, 1, 1, 1, 0);
    add_patch(0, 0, 128, 64, 16'h1234, 16'h5678, 16'h9ABC, 0, 1);
    add_patch(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1, 2, 3, 1, 1);
    add_patch(24'sh800000, 0, 24'sh7FFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
    add_patch(512, 0, 512, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1); // luxel off face
    wait_idle();

    // inverted face box, negative lobes, full range parameters
    write_reg(flacc_pkg::REG_MIN_X, 24'sd4096); write_reg(flacc_pkg::REG_MAX_X, -24'sd4096);
    write_reg(flacc_pkg::REG_MIN_Y, -24'sd2048); write_reg(flacc_pkg::REG_MAX_Y, 24'sd2048);
    write_reg(flacc_pkg::REG_RADIUS, 24'd9000); write_reg(flacc_pkg::REG_SCALE, 16'd100);
    write_reg(flacc_pkg::REG_CUBIC_B, 16'd0); write_reg(flacc_pkg::REG_CUBIC_C, 16'd32768);
    add_patch(0, 0, 300, 300, 16'hFFFF, 16'h00FF, 16'hFF00, 1, 0);
    add_patch(0, 0, 1900, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
    add_patch(0, 0, 0, 1500, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
    add_patch(-8000, 0, -8000, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
    add_patch(100, 0, 100, 0, 1, 1, 1, 1, 0); // luxel changes within run
    add_patch(100000, 0, 100000, 0, 5, 5, 5, 1, 1);
    wait_idle();

    // long receiver hold-off so the input queue fills
    write_reg(flacc_pkg::REG_MIN_X, -24'sd8388608); write_reg(flacc_pkg::REG_MAX_X, 24'sd8388607);
    write_reg(flacc_pkg::REG_MIN_Y, -24'sd8388608); write_reg(flacc_pkg::REG_MAX_Y, 24'sd8388607);
    write_reg(flacc_pkg::REG_RADIUS, 24'd512); write_reg(flacc_pkg::REG_SCALE, 16'd256);
    write_reg(flacc_pkg::REG_CUBIC_B, 16'd5461); write_reg(flacc_pkg::REG_CUBIC_C, 16'd5461);
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) random_run(1 + (i % 3), 600);
    wait_idle();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(flacc_pkg::REG_RADIUS, ph == 5 ? 24'hFFFFFF : 24'($urandom_range(0, 2048)));
      write_reg(flacc_pkg::REG_SCALE,
                ph == 4 ? 16'hFFFF : ph == 3 ? 16'h0 : 16'($urandom_range(32, 1024)));
      write_reg(flacc_pkg::REG_CUBIC_B, ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 32768)));
      write_reg(flacc_pkg::REG_CUBIC_C, ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 32768)));
      write_reg(flacc_pkg::REG_MIN_X, 24'($signed($urandom_range(0, 16384)) - 12288));
      write_reg(flacc_pkg::REG_MIN_Y, 24'($signed($urandom_range(0, 16384)) - 12288));
      write_reg(flacc_pkg::REG_MAX_X, 24'($signed($urandom_range(0, 16384)) - 4096));
      write_reg(flacc_pkg::REG_MAX_Y,
                ph == 1 ? 24'sh800000 : 24'($signed($urandom_range(0, 16384)) - 4096));
      for (int k = 0; k < 85; k += 0) begin
        int n;
        n = $urandom_range(1, 6);
        random_run(n, ph == 5 ? 40000 : 900);
        k += n;
      end
      wait_idle();
    end

    $display("covered %0d patches in %0d runs, %0d results checked", items_sent, runs_sent,
             results_seen);
    $display("settings: reset defaults, inverted face box, long output stall, 6 random sets");
    if (errors == 0) $display("filtered_luxel_accumulator_core: match");
    else $display("filtered_luxel_accumulator_core: mismatch");
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout");
    $display("filtered_luxel_accumulator_core: mismatch");
    $finish;
  end
endmodule
